[src/alr_pkg.sv]
// shared widths, the front-to-back command word and the pixel word
// no dependencies
`timescale 1ns / 1ps
package alr_pkg;
	localparam int CI   = 12;
	localparam int CF   = 8;
	localparam int GF   = 16;
	localparam int CW   = CI + CF;
	localparam int PW   = CI + 1;
	localparam int IW   = CI + GF + 1;
	localparam int HW   = 16;
	localparam int GW   = 18;
	localparam int SW   = 32;
	localparam int HSF  = 15;
	localparam int BW   = 9;
	localparam int DNUM = CW + 1 + GF;
	localparam int DDEN = CW + 1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic                 tick;
		logic                 steep;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic signed [GW-1:0] grad;
		logic signed [SW-1:0] hstep;
		logic signed [HW-1:0] hstart;
	} cmd_t;

	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic [BW-1:0]        br;
		logic signed [HW-1:0] h;
		logic                 last;
	} pix_t;
endpackage

[src/alr_div.sv]
// restoring unsigned divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps
module alr_div #(
	parameter int NUM_W = 37,
	parameter int DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign quo  = nq_q;
	assign done = done_q;
endmodule

[src/alr_front.sv]
// front end: takes input words, orders line endpoints, runs the two divisions
// and queues commands for the back end; uses alr_pkg and alr_div
`timescale 1ns / 1ps
module alr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic signed [alr_pkg::CW-1:0] start_x,
	input  logic signed [alr_pkg::CW-1:0] start_y,
	input  logic signed [alr_pkg::CW-1:0] end_x,
	input  logic signed [alr_pkg::CW-1:0] end_y,
	input  logic signed [alr_pkg::HW-1:0] start_height,
	input  logic signed [alr_pkg::HW-1:0] end_height,
	output alr_pkg::cmd_t                 cmd,
	output logic                          cmd_valid,
	input  logic                          cmd_pop
);
	localparam int CW = alr_pkg::CW;
	localparam int HW = alr_pkg::HW;
	localparam int GW = alr_pkg::GW;
	localparam int SW = alr_pkg::SW;
	localparam int GF = alr_pkg::GF;
	localparam int HSF = alr_pkg::HSF;
	localparam int DNUM = alr_pkg::DNUM;
	localparam int DDEN = alr_pkg::DDEN;

	localparam logic [1:0] F_IDLE = 2'd0, F_START = 2'd1, F_DIV = 2'd2, F_PUSH = 2'd3;

	logic [1:0] fst_q;
	logic       acc;
	logic signed [CW:0] ddx, ddy;
	logic [CW:0]        adx, ady;
	logic               steep;
	logic signed [CW-1:0] a0, b0, a1, b1;
	logic               ord;

	logic               steep_q;
	logic signed [CW-1:0] mx0_q, my0_q, mx1_q, my1_q;
	logic signed [HW-1:0] z0_q, z1_q;

	logic signed [CW:0] dx, dy;
	logic [CW:0]        abs_dy;
	logic signed [HW:0] dz, zsum;
	logic [HW:0]        abs_dz;
	logic               dx_zero;
	logic [DNUM-1:0]    num_g, num_h, q_g, q_h;
	logic               done_g, done_h;
	logic signed [GW-1:0] grad;
	logic signed [SW-1:0] hstep;
	alr_pkg::cmd_t      ld_cmd, wdata;

	alr_pkg::cmd_t      qmem [2];
	logic               wp_q, rp_q;
	logic [1:0]         cnt_q;
	logic               wr_tick, wr_ld, wr;

	assign acc  = push && !full;
	assign full = (fst_q != F_IDLE) || (cnt_q == 2'd2);

	// steepness and endpoint order straight from the ports
	assign ddx   = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
	assign ddy   = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
	assign adx   = ddx[CW] ? $unsigned(-ddx) : $unsigned(ddx);
	assign ady   = ddy[CW] ? $unsigned(-ddy) : $unsigned(ddy);
	assign steep = ady > adx;
	assign a0    = steep ? start_y : start_x;
	assign b0    = steep ? start_x : start_y;
	assign a1    = steep ? end_y : end_x;
	assign b1    = steep ? end_x : end_y;
	assign ord   = a0 > a1;

	always_ff @(posedge clk) begin
		if (acc && (kind == alr_pkg::KIND_LOAD)) begin
			steep_q <= steep;
			mx0_q   <= ord ? a1 : a0;
			my0_q   <= ord ? b1 : b0;
			mx1_q   <= ord ? a0 : a1;
			my1_q   <= ord ? b0 : b1;
			z0_q    <= ord ? end_height : start_height;
			z1_q    <= ord ? start_height : end_height;
		end
	end

	assign dx      = {mx1_q[CW-1], mx1_q} - {mx0_q[CW-1], mx0_q};
	assign dy      = {my1_q[CW-1], my1_q} - {my0_q[CW-1], my0_q};
	assign abs_dy  = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
	assign dz      = {z1_q[HW-1], z1_q} - {z0_q[HW-1], z0_q};
	assign abs_dz  = dz[HW] ? $unsigned(-dz) : $unsigned(dz);
	assign zsum    = {z0_q[HW-1], z0_q} + {z1_q[HW-1], z1_q};
	assign dx_zero = (dx == '0);
	assign num_g   = {abs_dy, {GF{1'b0}}};
	assign num_h   = DNUM'({abs_dz, {HSF{1'b0}}});

	alr_div #(.NUM_W(DNUM), .DEN_W(DDEN)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(fst_q == F_START),
		.num(num_g), .den(dx), .quo(q_g), .done(done_g)
	);

	alr_div #(.NUM_W(DNUM), .DEN_W(DDEN)) u_div_h (
		.clk(clk), .arst_n(arst_n), .start(fst_q == F_START),
		.num(num_h), .den(dx), .quo(q_h), .done(done_h)
	);

	assign grad  = dy[CW] ? -$signed(q_g[GW-1:0]) : $signed(q_g[GW-1:0]);
	assign hstep = dz[HW] ? -$signed(q_h[SW-1:0]) : $signed(q_h[SW-1:0]);

	always_comb begin
		ld_cmd        = '0;
		ld_cmd.steep  = steep_q;
		ld_cmd.x0     = mx0_q;
		ld_cmd.y0     = my0_q;
		ld_cmd.x1     = mx1_q;
		ld_cmd.y1     = my1_q;
		ld_cmd.grad   = dx_zero ? '0 : grad;
		ld_cmd.hstep  = dx_zero ? '0 : hstep;
		ld_cmd.hstart = dx_zero ? zsum[HW:1] : z0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			unique case (fst_q)
				F_IDLE:  if (acc && (kind == alr_pkg::KIND_LOAD)) fst_q <= F_START;
				F_START: fst_q <= F_DIV;
				F_DIV:   if (done_g && done_h) fst_q <= F_PUSH;
				F_PUSH:  if (cnt_q != 2'd2) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	// two-entry command queue
	assign wr_tick = acc && (kind == alr_pkg::KIND_TICK);
	assign wr_ld   = (fst_q == F_PUSH) && (cnt_q != 2'd2);
	assign wr      = wr_tick || wr_ld;

	always_comb begin
		wdata = ld_cmd;
		if (wr_tick) begin
			wdata      = '0;
			wdata.tick = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) qmem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, cmd_pop};
		end
	end

	assign cmd       = qmem[rp_q];
	assign cmd_valid = (cnt_q != 2'd0);
endmodule

[src/alr_back.sv]
// back end: holds the line state, produces endpoint and span pixel pairs
// and buffers result words; uses alr_pkg
`timescale 1ns / 1ps
module alr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  alr_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	output alr_pkg::pix_t opix,
	output logic          empty,
	input  logic          pop
);
	localparam int CW = alr_pkg::CW;
	localparam int CF = alr_pkg::CF;
	localparam int GF = alr_pkg::GF;
	localparam int PW = alr_pkg::PW;
	localparam int IW = alr_pkg::IW;
	localparam int HW = alr_pkg::HW;
	localparam int GW = alr_pkg::GW;
	localparam int SW = alr_pkg::SW;
	localparam int BW = alr_pkg::BW;
	localparam int HSF = alr_pkg::HSF;
	localparam int OW = CW + 2;
	localparam int HPW = SW + OW;
	localparam int HQW = HPW - HSF;
	localparam int HSW = HQW + 1;
	localparam int EPW = GW + CF + 1;
	localparam int YW = CW + GF + 1;
	localparam int WW = 2 * BW;
	localparam logic signed [HPW-1:0] HRND = HPW'(1) <<< (HSF - 1);
	localparam logic signed [HSW-1:0] HMAX = HSW'(32767);
	localparam logic signed [HSW-1:0] HMIN = HSW'(-32768);
	localparam logic [BW-1:0] FULLW = BW'(1 << CF);

	localparam logic [3:0] B_IDLE = 4'd0, B_LD0 = 4'd1, B_LD1 = 4'd2, B_LD2 = 4'd3,
		B_LD3 = 4'd4, B_MUL = 4'd5, B_SUM = 4'd6, B_OUT0 = 4'd7, B_OUT1 = 4'd8;

	logic [3:0] st_q;

	logic                 active_q, steep_q, pend_q;
	logic signed [PW-1:0] cur_q, lastc_q, c1n_q;
	logic signed [GW-1:0] grad_q;
	logic signed [IW-1:0] acc_q;
	logic signed [HW-1:0] hstart_q;
	logic signed [SW-1:0] hstep_q;
	logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q;

	logic signed [PW-1:0] exend_q;
	logic [CF-1:0]        efr_q;
	logic signed [EPW-1:0] eprod_q;

	logic signed [PW-1:0] pcol_q;
	logic signed [IW-1:0] picpt_q;
	logic [BW-1:0]        pgap_q;
	logic                 plast_q;
	logic signed [HPW-1:0] hprod_q;
	logic [WW-1:0]        wlo_q, whi_q;
	logic signed [HW-1:0] h_q;

	logic signed [CW-1:0] sx, sy;
	logic signed [CW:0]   xsum;
	logic signed [PW-1:0] xend;
	logic signed [OW-1:0] offe, offh;
	logic signed [CF:0]   off9;
	logic signed [YW-1:0] yfull;
	logic signed [IW-1:0] yend, gradx;
	logic signed [PW-1:0] nxt;
	logic                 more;
	logic [CF-1:0]        f8;
	logic signed [HPW-1:0] hround;
	logic signed [HSW-1:0] hsum;
	logic signed [PW-1:0] yi;
	alr_pkg::pix_t        wpix;
	logic                 ofull, opush;

	alr_pkg::pix_t        omem [4];
	logic [1:0]           owp_q, orp_q;
	logic [2:0]           ocnt_q;

	assign cmd_pop = (st_q == B_IDLE) && cmd_valid;
	assign ofull   = (ocnt_q == 3'd4);

	// endpoint column, offset to the column center and the intercept there
	assign sx    = (st_q == B_LD0 || st_q == B_LD1) ? x0_q : x1_q;
	assign sy    = (st_q == B_LD1) ? y0_q : y1_q;
	assign xsum  = {sx[CW-1], sx} + (CW+1)'(1 << (CF - 1));
	assign xend  = xsum[CW:CF];
	assign offe  = {xend[PW-1], xend, {CF{1'b0}}} - {{2{sx[CW-1]}}, sx};
	assign off9  = offe[CF:0];
	assign yfull = {sy[CW-1], sy, {GF{1'b0}}} + {{(YW-EPW){eprod_q[EPW-1]}}, eprod_q};
	assign yend  = yfull[YW-1:CF];
	assign gradx = {{(IW-GW){grad_q[GW-1]}}, grad_q};
	assign nxt   = cur_q + PW'(1);
	assign more  = c1n_q < exend_q;

	// height interpolation
	assign offh   = {pcol_q[PW-1], pcol_q, {CF{1'b0}}} - {{2{x0_q[CW-1]}}, x0_q};
	assign f8     = picpt_q[GF-1:GF-CF];
	assign hround = hprod_q + HRND;
	assign hsum   = {hround[HPW-1], hround[HPW-1:HSF]}
		+ {{(HSW-HW){hstart_q[HW-1]}}, hstart_q};
	assign yi     = picpt_q[IW-1:GF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			active_q <= 1'b0;
			steep_q  <= 1'b0;
			pend_q   <= 1'b0;
			cur_q    <= '0;
			lastc_q  <= '0;
			c1n_q    <= '0;
			grad_q   <= '0;
			acc_q    <= '0;
			hstart_q <= '0;
			hstep_q  <= '0;
			x0_q     <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd.tick) begin
							if (active_q) begin
								cur_q    <= nxt;
								active_q <= nxt < lastc_q;
								acc_q    <= acc_q + gradx;
								st_q     <= B_MUL;
							end
						end else begin
							steep_q  <= cmd.steep;
							grad_q   <= cmd.grad;
							hstep_q  <= cmd.hstep;
							hstart_q <= cmd.hstart;
							x0_q     <= cmd.x0;
							st_q     <= B_LD0;
						end
					end
				end
				B_LD0: st_q <= B_LD1;
				B_LD1: begin
					acc_q  <= yend + gradx;
					c1n_q  <= exend_q + PW'(1);
					pend_q <= 1'b1;
					st_q   <= B_MUL;
				end
				B_LD2: st_q <= B_LD3;
				B_LD3: begin
					cur_q    <= c1n_q;
					lastc_q  <= exend_q;
					active_q <= more;
					pend_q   <= 1'b0;
					st_q     <= B_MUL;
				end
				B_MUL: st_q <= B_SUM;
				B_SUM: st_q <= B_OUT0;
				B_OUT0: if (!ofull) st_q <= B_OUT1;
				B_OUT1: if (!ofull) st_q <= pend_q ? B_LD2 : B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.tick) begin
			y0_q <= cmd.y0;
			x1_q <= cmd.x1;
			y1_q <= cmd.y1;
		end
		if (st_q == B_LD0 || st_q == B_LD2) begin
			exend_q <= xend;
			efr_q   <= xsum[CF-1:0];
			eprod_q <= grad_q * off9;
		end
		if (cmd_pop && cmd.tick) begin
			pcol_q  <= cur_q;
			picpt_q <= acc_q;
			pgap_q  <= FULLW;
			plast_q <= !(nxt < lastc_q);
		end else if (st_q == B_LD1) begin
			pcol_q  <= exend_q;
			picpt_q <= yend;
			pgap_q  <= FULLW - {1'b0, efr_q};
			plast_q <= 1'b0;
		end else if (st_q == B_LD3) begin
			pcol_q  <= exend_q;
			picpt_q <= yend;
			pgap_q  <= {1'b0, efr_q};
			plast_q <= !more;
		end
		if (st_q == B_MUL) begin
			hprod_q <= hstep_q * offh;
			wlo_q   <= (FULLW - {1'b0, f8}) * pgap_q;
			whi_q   <= {1'b0, f8} * pgap_q;
		end
		if (st_q == B_SUM) begin
			if (hsum > HMAX) h_q <= HMAX[HW-1:0];
			else if (hsum < HMIN) h_q <= HMIN[HW-1:0];
			else h_q <= hsum[HW-1:0];
		end
	end

	// pixel word, swapped back for steep lines
	always_comb begin
		wpix      = '0;
		wpix.h    = h_q;
		if (st_q == B_OUT1) begin
			wpix.px   = steep_q ? yi + PW'(1) : pcol_q;
			wpix.py   = steep_q ? pcol_q : yi + PW'(1);
			wpix.br   = whi_q[CF+BW-1:CF];
			wpix.last = plast_q;
		end else begin
			wpix.px   = steep_q ? yi : pcol_q;
			wpix.py   = steep_q ? pcol_q : yi;
			wpix.br   = wlo_q[CF+BW-1:CF];
			wpix.last = 1'b0;
		end
	end

	assign opush = (st_q == B_OUT0 || st_q == B_OUT1) && !ofull;

	always_ff @(posedge clk) begin
		if (opush) omem[owp_q] <= wpix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) owp_q <= owp_q + 2'd1;
			if (pop && !empty) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + {2'b0, opush} - {2'b0, pop && !empty};
		end
	end

	assign empty = (ocnt_q == 3'd0);
	assign opix  = omem[orp_q];
endmodule

[src/antialiased_line_rasterizer_top.sv]
// a span word passes B_MUL and B_SUM before its first pixel is written; the
// back end holds each pixel while the result queue is full
// a load word holds full until its command is queued; two 37-step restoring
// dividers make the gradient and the height step, one quotient bit per cycle
// reset clears the line state, the command queue and the result queue
`timescale 1ns / 1ps
module antialiased_line_rasterizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic signed [alr_pkg::CW-1:0] start_x,
	input  logic signed [alr_pkg::CW-1:0] start_y,
	input  logic signed [alr_pkg::CW-1:0] end_x,
	input  logic signed [alr_pkg::CW-1:0] end_y,
	input  logic signed [alr_pkg::HW-1:0] start_height,
	input  logic signed [alr_pkg::HW-1:0] end_height,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [alr_pkg::PW-1:0] pixel_x,
	output logic signed [alr_pkg::PW-1:0] pixel_y,
	output logic [alr_pkg::BW-1:0]        brightness,
	output logic signed [alr_pkg::HW-1:0] height,
	output logic                          last_of_line
);
	alr_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_pop;
	alr_pkg::pix_t opix;

	alr_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.start_height(start_height), .end_height(end_height),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	alr_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .opix(opix), .empty(empty), .pop(pop)
	);

	assign pixel_x      = opix.px;
	assign pixel_y      = opix.py;
	assign brightness   = opix.br;
	assign height       = opix.h;
	assign last_of_line = opix.last;
endmodule
